### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/gtti_pkg.sv
// ----------------------------------------------------------------------------
// gtti_pkg
// shared widths and lane control/status types for the gain interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package gtti_pkg;

    localparam int NUM_LANES   = 4;
    localparam int TIME_W      = 32;
    localparam int GAIN_W      = 32;
    localparam int NUM_W       = 64;
    localparam int TDATA_IN_W  = TIME_W + NUM_LANES * GAIN_W;
    localparam int TDATA_OUT_W = NUM_LANES * GAIN_W;

    // control from the top level to every lane
    typedef struct packed {
        logic row_accept;   // a row word is taken this cycle
        logic last;         // that row closes the table
        logic clear;        // target time written, drop the brackets
        logic take;         // merge stage takes the lane results
    } lane_ctl_t;

    // status from a lane to the merge stage
    typedef struct packed {
        logic done;         // result held and stable
        logic error;        // no valid row or result not positive
    } lane_stat_t;

endpackage

`default_nettype wire

### rtl/gtti_div.sv
// ----------------------------------------------------------------------------
// gtti_div
// signed 64 by unsigned 32 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gtti_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [gtti_pkg::NUM_W-1:0]    num,
    input  wire logic        [gtti_pkg::TIME_W-1:0]   den,
    output logic                                      done,
    output logic signed      [gtti_pkg::GAIN_W-1:0]   quo
);

    localparam int STEPS = gtti_pkg::GAIN_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int HW    = gtti_pkg::NUM_W / 2;

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          neg_reg;
    logic [HW-1:0]                 rem_reg;
    logic [HW-1:0]                 dvd_reg;
    logic [gtti_pkg::GAIN_W-1:0]   quo_reg;

    logic [gtti_pkg::NUM_W-1:0]    mag;
    logic [HW:0]                   trial;
    logic [HW:0]                   diff;
    logic                          fits;

    // magnitude stays below den * 2^32, so the high half already fits below den
    assign mag   = num[gtti_pkg::NUM_W-1] ? gtti_pkg::NUM_W'(-num) : gtti_pkg::NUM_W'(num);
    assign trial = {rem_reg, dvd_reg[HW-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[gtti_pkg::NUM_W-1];
            rem_reg <= mag[gtti_pkg::NUM_W-1:HW];
            dvd_reg <= mag[HW-1:0];
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[HW-1:0] : trial[HW-1:0];
            dvd_reg <= {dvd_reg[HW-2:0], 1'b0};
            quo_reg <= {quo_reg[gtti_pkg::GAIN_W-2:0], fits};
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign quo  = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/gtti_lane.sv
// ----------------------------------------------------------------------------
// gtti_lane
// one channel: bracket tracking per row and the blend sequence on the last row
// ----------------------------------------------------------------------------
`default_nettype none

module gtti_lane (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic        [gtti_pkg::TIME_W-1:0]  tgt_time,
    input  wire gtti_pkg::lane_ctl_t                 ctl,
    input  wire logic        [gtti_pkg::TIME_W-1:0]  row_time,
    input  wire logic signed [gtti_pkg::GAIN_W-1:0]  row_gain,
    input  wire logic                                row_valid,
    output gtti_pkg::lane_stat_t                     stat,
    output logic signed      [gtti_pkg::GAIN_W-1:0]  result
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL_B    = 7'b0000010,
        ST_MUL_A    = 7'b0000100,
        ST_SUM      = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } lane_state_t;

    localparam int TW = gtti_pkg::TIME_W;
    localparam int GW = gtti_pkg::GAIN_W;
    localparam int NW = gtti_pkg::NUM_W;

    lane_state_t state_reg, state_next;

    logic                 bf_reg, af_reg;
    logic [TW-1:0]        bt_reg, at_reg;
    logic signed [GW-1:0] bg_reg, ag_reg;

    logic signed [NW-1:0] p1_reg, p2_reg, num_reg;
    logic signed [GW-1:0] res_reg;

    logic                 upd_b, upd_a;
    logic                 interp;
    logic [TW-1:0]        wa, wb, den;
    logic signed [GW-1:0] mul_gain;
    logic [TW-1:0]        mul_wt;
    logic signed [TW:0]   mul_wt_s;
    logic signed [NW:0]   prod;
    logic signed [GW-1:0] direct;
    logic                 div_done;
    logic signed [GW-1:0] div_quo;

    // latest row at or before the target, earliest at or after; ties keep the first
    assign upd_b = (row_time <= tgt_time) && (!bf_reg || row_time > bt_reg);
    assign upd_a = (row_time >= tgt_time) && (!af_reg || row_time < at_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bf_reg <= 1'b0;
            af_reg <= 1'b0;
        end else if (ctl.clear || ctl.take) begin
            bf_reg <= 1'b0;
            af_reg <= 1'b0;
        end else if (ctl.row_accept && row_valid) begin
            if (upd_b) begin
                bf_reg <= 1'b1;
            end
            if (upd_a) begin
                af_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.row_accept && row_valid && upd_b) begin
            bt_reg <= row_time;
            bg_reg <= row_gain;
        end
        if (ctl.row_accept && row_valid && upd_a) begin
            at_reg <= row_time;
            ag_reg <= row_gain;
        end
    end

    // blend weights; both brackets bound the target so none of these wrap
    assign interp   = bf_reg && af_reg && (bt_reg != at_reg);
    assign wa       = tgt_time - bt_reg;
    assign wb       = at_reg - tgt_time;
    assign den      = at_reg - bt_reg;
    assign direct   = bf_reg ? bg_reg : (af_reg ? ag_reg : '0);

    // one multiplier, used for the before term and then the after term
    assign mul_gain = (state_reg == ST_MUL_B) ? bg_reg : ag_reg;
    assign mul_wt   = (state_reg == ST_MUL_B) ? wb : wa;
    assign mul_wt_s = $signed({1'b0, mul_wt});
    assign prod     = mul_gain * mul_wt_s;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.row_accept && ctl.last) begin
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B:    state_next = interp ? ST_MUL_A : ST_DONE;
            ST_MUL_A:    state_next = ST_SUM;
            ST_SUM:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctl.take) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL_B) begin
            p1_reg  <= prod[NW-1:0];
            res_reg <= direct;
        end
        if (state_reg == ST_MUL_A) begin
            p2_reg <= prod[NW-1:0];
        end
        if (state_reg == ST_SUM) begin
            num_reg <= p1_reg + p2_reg;
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            res_reg <= div_quo;
        end
    end

    gtti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIV_GO),
        .num     (num_reg),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign stat.done  = (state_reg == ST_DONE);
    assign stat.error = res_reg[GW-1] || (res_reg == '0);
    assign result     = res_reg;

endmodule

`default_nettype wire

### rtl/gtti_merge.sv
// ----------------------------------------------------------------------------
// gtti_merge
// waits for all lanes, packs their results into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module gtti_merge (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire gtti_pkg::lane_stat_t [gtti_pkg::NUM_LANES-1:0] lane_stat,
    input  wire logic [gtti_pkg::NUM_LANES-1:0][gtti_pkg::GAIN_W-1:0] lane_result,
    output logic                                            take,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    output logic [gtti_pkg::TDATA_OUT_W-1:0]                m_tdata,
    output logic [gtti_pkg::NUM_LANES-1:0]                  m_tuser
);

    localparam int GW = gtti_pkg::GAIN_W;

    logic                                m_tvalid_reg;
    logic [gtti_pkg::TDATA_OUT_W-1:0]    m_tdata_reg;
    logic [gtti_pkg::NUM_LANES-1:0]      m_tuser_reg;
    logic                                all_done;

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < gtti_pkg::NUM_LANES; i++) begin
            all_done = all_done & lane_stat[i].done;
        end
    end

    // load once every lane holds its result and the output word is free
    assign take = all_done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < gtti_pkg::NUM_LANES; i++) begin
                m_tdata_reg[i*GW +: GW] <= lane_result[i];
                m_tuser_reg[i]          <= lane_stat[i].error;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### rtl/gain_table_time_interpolation_top.sv
// ----------------------------------------------------------------------------
// gain_table_time_interpolation_top
// four-channel gain table interpolation at a programmable target time
// ----------------------------------------------------------------------------
// Calibration rows stream in on the slave side, in any order, one row per word.
// Each of four lanes keeps, for its channel, the latest valid row at or before
// the target time and the earliest valid row at or after it. The word marked
// with s_tlast closes the table: every lane then blends its two brackets
// (g_before*(t_after-T) + g_after*(T-t_before)) / (t_after-t_before), truncated
// toward zero, and one word with the four gains and four error flags leaves on
// the master side. A lone bracket, or two brackets at one time, passes the
// before gain (else the one found); a channel with no valid row gives zero.
// An error flag is set for a result of zero or less. Writing the target time
// register drops all brackets. Rate: one ordinary row per cycle while no target
// write is pending. The closing row holds s_tready low while the lanes work:
// through two multiply steps, the sum, the divider start, 32 one-bit-per-cycle
// divide steps, the wait for the divider to finish and the hand-over of the
// results when any lane interpolates, through one multiply step and the hand-over
// when none does, and through any wait for the output register to be taken. A
// finished word may wait on the master side while the next table already streams in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gain_table_time_interpolation_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // target time register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gtti_pkg::TIME_W-1:0]        cfg_data,

    // table rows
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // row_time, gain_ch0, gain_ch1, gain_ch2, gain_ch3 (32 bits each)
    input  wire logic [gtti_pkg::TDATA_IN_W-1:0]    s_tdata,
    // valid_ch0, valid_ch1, valid_ch2, valid_ch3
    input  wire logic [gtti_pkg::NUM_LANES-1:0]     s_tuser,
    // last_row
    input  wire logic                               s_tlast,

    // interpolated gains
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // result_ch0, result_ch1, result_ch2, result_ch3 (32 bits each)
    output logic [gtti_pkg::TDATA_OUT_W-1:0]        m_tdata,
    // error_ch0, error_ch1, error_ch2, error_ch3
    output logic [gtti_pkg::NUM_LANES-1:0]          m_tuser
);

    localparam int TW = gtti_pkg::TIME_W;
    localparam int GW = gtti_pkg::GAIN_W;
    localparam int NL = gtti_pkg::NUM_LANES;

    logic [TW-1:0]                 target_reg;
    logic                          busy_reg;
    logic                          row_accept;
    logic                          cfg_accept;
    logic                          take;
    gtti_pkg::lane_ctl_t           lane_ctl;
    gtti_pkg::lane_stat_t [NL-1:0] lane_stat;
    logic [NL-1:0][GW-1:0]         lane_result;
    logic [NL-1:0]                 lane_done;

    // a register write wins over a row in the same cycle
    assign cfg_ready  = !busy_reg;
    assign s_tready   = !busy_reg && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign row_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_accept) begin
            target_reg <= cfg_data;
        end
    end

    // busy from the closing row until the merge stage takes the results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (row_accept && s_tlast) begin
            busy_reg <= 1'b1;
        end else if (take) begin
            busy_reg <= 1'b0;
        end
    end

    assign lane_ctl.row_accept = row_accept;
    assign lane_ctl.last       = s_tlast;
    assign lane_ctl.clear      = cfg_accept;
    assign lane_ctl.take       = take;

    // one lane per channel, all fed the same row time
    for (genvar i = 0; i < NL; i++) begin : g_lane
        logic signed [GW-1:0] lane_res;

        gtti_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tgt_time    (target_reg),
            .ctl         (lane_ctl),
            .row_time    (s_tdata[TW-1:0]),
            .row_gain    ($signed(s_tdata[TW + i*GW +: GW])),
            .row_valid   (s_tuser[i]),
            .stat        (lane_stat[i]),
            .result      (lane_res)
        );

        assign lane_result[i] = lane_res;
        assign lane_done[i]   = lane_stat[i].done;
    end

    gtti_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lane_stat   (lane_stat),
        .lane_result (lane_result),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // closing row must stall the row channel while the lanes work
    `ASSERT_NEXT(a_last_stalls, aclk, aresetn, row_accept && s_tlast, !s_tready, "row taken during blend")

    // results are taken only when every lane has finished
    `ASSERT_SAME(a_take_all_done, aclk, aresetn, take, lane_done == {NL{1'b1}}, "partial lane take")

    // an idle block holds no finished lane result
    `ASSERT_SAME(a_idle_no_done, aclk, aresetn, !busy_reg, lane_done == '0, "stale lane result")

endmodule

`default_nettype wire

### tb/gain_table_time_interpolation_top_tb.sv
// ----------------------------------------------------------------------------
// gain_table_time_interpolation_top_tb
// self-checking bench for the four-channel gain table interpolator
// ----------------------------------------------------------------------------
// Streams calibration tables into the block and tracks the per-channel
// before/after brackets in a scoreboard that computes the expected blended
// gains and error flags. Every result word is compared field by field with
// the oldest expected word. A directed part covers field extremes, lone
// brackets, rows exactly at the target time, duplicate time stamps, empty
// channels, non-positive results and the bracket clear on a target write.
// Random tables follow over several target times, with random idling on
// both sides, two long receiver hold-offs and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_table_time_interpolation_top_tb;

    localparam int TIME_W      = gtti_pkg::TIME_W;
    localparam int GAIN_W      = gtti_pkg::GAIN_W;
    localparam int NUM_LANES   = gtti_pkg::NUM_LANES;
    localparam int TDATA_IN_W  = gtti_pkg::TDATA_IN_W;
    localparam int TDATA_OUT_W = gtti_pkg::TDATA_OUT_W;

    typedef struct {
        bit [TIME_W-1:0]    row_time;
        bit [GAIN_W-1:0]    gain [NUM_LANES];
        bit [NUM_LANES-1:0] present;
        bit                 last;
    } table_row_t;

    typedef struct {
        bit [GAIN_W-1:0]    gain [NUM_LANES];
        bit [NUM_LANES-1:0] err;
    } gains_word_t;

    // bracket tracking per channel and the queue of blended gain words
    class gain_scoreboard;
        bit [TIME_W-1:0]    target;
        bit [TIME_W-1:0]    lo_time [NUM_LANES];
        bit [GAIN_W-1:0]    lo_gain [NUM_LANES];
        bit                 lo_seen [NUM_LANES];
        bit [TIME_W-1:0]    hi_time [NUM_LANES];
        bit [GAIN_W-1:0]    hi_gain [NUM_LANES];
        bit                 hi_seen [NUM_LANES];
        gains_word_t        gains_q [$];
        int                 mismatches;
        int                 strays;
        int                 reports;

        function new();
            target     = '0;
            mismatches = 0;
            strays     = 0;
            reports    = 0;
            clear_brackets();
        endfunction

        function void clear_brackets();
            for (int c = 0; c < NUM_LANES; c++) begin
                lo_time[c] = '0;
                lo_gain[c] = '0;
                lo_seen[c] = 1'b0;
                hi_time[c] = '1;
                hi_gain[c] = '0;
                hi_seen[c] = 1'b0;
            end
        endfunction

        function void set_target(bit [TIME_W-1:0] t);
            target = t;
            clear_brackets();
        endfunction

        function void blend(int c, output bit [GAIN_W-1:0] g, output bit bad);
            longint r, wa, wb, span;
            if (lo_seen[c] && hi_seen[c]) begin
                if (lo_time[c] == hi_time[c]) begin
                    r = longint'($signed(lo_gain[c]));
                end else begin
                    wa   = longint'(target) - longint'(lo_time[c]);
                    wb   = longint'(hi_time[c]) - longint'(target);
                    span = longint'(hi_time[c]) - longint'(lo_time[c]);
                    r = (longint'($signed(lo_gain[c])) * wb
                         + longint'($signed(hi_gain[c])) * wa) / span;
                end
            end else if (lo_seen[c]) begin
                r = longint'($signed(lo_gain[c]));
            end else if (hi_seen[c]) begin
                r = longint'($signed(hi_gain[c]));
            end else begin
                g   = '0;
                bad = 1'b1;
                return;
            end
            g   = r[GAIN_W-1:0];
            bad = (r <= 0);
        endfunction

        function void note_row(table_row_t r);
            gains_word_t w;
            for (int c = 0; c < NUM_LANES; c++) begin
                if (!r.present[c])
                    continue;
                // strict compares keep the first row among equal time stamps
                if (r.row_time <= target && (!lo_seen[c] || r.row_time > lo_time[c])) begin
                    lo_time[c] = r.row_time;
                    lo_gain[c] = r.gain[c];
                    lo_seen[c] = 1'b1;
                end
                if (r.row_time >= target && (!hi_seen[c] || r.row_time < hi_time[c])) begin
                    hi_time[c] = r.row_time;
                    hi_gain[c] = r.gain[c];
                    hi_seen[c] = 1'b1;
                end
            end
            if (!r.last)
                return;
            for (int c = 0; c < NUM_LANES; c++)
                blend(c, w.gain[c], w.err[c]);
            gains_q.insert(gains_q.size(), w);
            clear_brackets();
        endfunction

        function void check_result(bit [TDATA_OUT_W-1:0] d, bit [NUM_LANES-1:0] e);
            gains_word_t w;
            if (gains_q.size() == 0) begin
                strays++;
                if (reports < 10)
                    $display("unexpected result word: gains %h errors %b", d, e);
                reports++;
                return;
            end
            w = gains_q.pop_front();
            for (int c = 0; c < NUM_LANES; c++) begin
                if (d[c*GAIN_W +: GAIN_W] !== w.gain[c] || e[c] !== w.err[c]) begin
                    mismatches++;
                    if (reports < 10)
                        $display("ch%0d: expected gain %h err %b, got gain %h err %b",
                                 c, w.gain[c], w.err[c], d[c*GAIN_W +: GAIN_W], e[c]);
                    reports++;
                end
            end
        endfunction

        function int pending();
            return gains_q.size();
        endfunction

        function int failures();
            return mismatches + strays + gains_q.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [TIME_W-1:0]          cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [TDATA_IN_W-1:0]      s_tdata;
    logic [NUM_LANES-1:0]       s_tuser;
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_OUT_W-1:0]     m_tdata;
    logic [NUM_LANES-1:0]       m_tuser;

    gain_scoreboard sb = new();

    bit calm          = 1'b0;   // no idling on either side
    int hold_requests = 0;      // each increment asks for one receiver hold-off
    int rows_sent     = 0;

    gain_table_time_interpolation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_row(input table_row_t r);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 37)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.gain[3], r.gain[2], r.gain[1], r.gain[0], r.row_time};
        s_tuser  <= r.present;
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_row(r);
        rows_sent++;
    endtask

    task automatic put(input bit [TIME_W-1:0] t, input bit [GAIN_W-1:0] g0,
                       input bit [GAIN_W-1:0] g1, input bit [GAIN_W-1:0] g2,
                       input bit [GAIN_W-1:0] g3, input bit [NUM_LANES-1:0] present,
                       input bit last);
        table_row_t r;
        r.row_time = t;
        r.gain[0]  = g0;
        r.gain[1]  = g1;
        r.gain[2]  = g2;
        r.gain[3]  = g3;
        r.present  = present;
        r.last     = last;
        send_row(r);
    endtask

    // stop offering rows until every expected word is back, then idle a while
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_target(input bit [TIME_W-1:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_target(t);
    endtask

    function automatic table_row_t make_row(bit [TIME_W-1:0] tgt, bit last);
        table_row_t r;
        longint t;
        case ($urandom_range(0, 19))
            0, 1, 2:    r.row_time = tgt;
            3:          r.row_time = '0;
            4:          r.row_time = '1;
            5, 6, 7, 8: r.row_time = $urandom;
            default: begin
                t = longint'(tgt) + longint'($urandom_range(0, 4000)) - 64'sd2000;
                if (t < 0)
                    t = 0;
                if (t > 64'sh0_FFFF_FFFF)
                    t = 64'sh0_FFFF_FFFF;
                r.row_time = t[TIME_W-1:0];
            end
        endcase
        for (int c = 0; c < NUM_LANES; c++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: r.gain[c] = $urandom;
                5, 6:          r.gain[c] = $urandom_range(0, 400) - 200;
                default:       r.gain[c] = $urandom_range(32'h0000_1000, 32'h0080_0000);
            endcase
            r.present[c] = ($urandom_range(0, 9) < 7);
        end
        r.last = last;
        return r;
    endfunction

    // result side: random stalls, long hold-off on request
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    initial begin
        int tables;
        int phase;
        int n_rows;
        bit [TIME_W-1:0] tgt;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // target 0 after reset: one row exactly at the target closes the table
        put(32'd0, 32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 4'b1111, 1'b1);
        drain(50);
        write_target(32'd1000);

        // two-sided brackets, duplicate time stamp, stale before row, extreme gains
        put(32'd900,  32'h0001_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 4'b1111, 1'b0);
        put(32'd1100, 32'h0003_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 4'b1111, 1'b0);
        put(32'd1100, 32'h0009_0000, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 4'b1111, 1'b0);
        put(32'd500,  32'h0050_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'b1111, 1'b0);
        put(32'd2000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'b0000, 1'b1);

        // lone brackets, zero gain, exact hit, channel with no valid row
        put(32'd10,   32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 4'b0001, 1'b0);
        put(32'd5000, 32'hFFFF_0000, 32'h0002_8000, 32'h5555_5555, 32'h0F0F_0F0F, 4'b0010, 1'b0);
        put(32'd1000, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h0001_8000, 32'h0F0F_0F0F, 4'b0100, 1'b1);

        // unfinished table, then a target write must drop its brackets
        put(32'd999,  32'h0007_0000, 32'h0007_0000, 32'h0007_0000, 32'h0007_0000, 4'b1111, 1'b0);
        put(32'd1001, 32'h0008_0000, 32'h0008_0000, 32'h0008_0000, 32'h0008_0000, 4'b1111, 1'b0);
        drain(50);
        write_target(32'hFFFF_FFFF);

        put(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE,
            4'b1111, 1'b0);
        put(32'd0,         32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444,
            4'b1111, 1'b0);
        put(32'h8000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
            4'b1100, 1'b1);
        drain(50);
        write_target(32'd0);

        put(32'hFFFF_FFFF, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0040_0000,
            4'b1111, 1'b0);
        put(32'd0,         32'hFFFF_FFFB, 32'h0000_0007, 32'h0000_0000, 32'h8000_0001,
            4'b1010, 1'b0);
        put(32'd77,        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            4'b1111, 1'b1);

        // random tables over a series of target times
        tables = 0;
        phase  = 0;
        while (rows_sent < 745) begin
            if (tables % 20 == 0) begin
                drain(50);
                case (phase)
                    0:       tgt = $urandom;
                    1:       tgt = '0;
                    2:       tgt = '1;
                    default: begin
                        case ($urandom_range(0, 2))
                            0:       tgt = $urandom;
                            1:       tgt = $urandom_range(0, 5000);
                            default: tgt = 32'hFFFF_F000 + $urandom_range(0, 4095);
                        endcase
                    end
                endcase
                write_target(tgt);
                phase++;
            end
            calm = (tables >= 30 && tables < 45);
            if (tables == 12 || tables == 70)
                hold_requests++;
            if (tables == 55)
                drain(0);
            case ($urandom_range(0, 19))
                0, 1, 2: n_rows = $urandom_range(7, 16);
                3:       n_rows = 1;
                default: n_rows = $urandom_range(1, 6);
            endcase
            for (int i = 0; i < n_rows; i++)
                send_row(make_row(sb.target, i == n_rows - 1));
            tables++;
        end
        calm = 1'b0;

        drain(60);
        if (sb.failures() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### gain_table_time_interpolation_top.f
+incdir+rtl
rtl/gtti_pkg.sv
rtl/gtti_div.sv
rtl/gtti_lane.sv
rtl/gtti_merge.sv
rtl/gain_table_time_interpolation_top.sv
tb/gain_table_time_interpolation_top_tb.sv
